// File: sv/mpp_pkg.sv
`timescale 1ns / 1ps

package mpp_pkg;

   localparam int MAX_DIM   = 8;
   localparam int DIM_W     = $clog2(MAX_DIM);
   localparam int ADDR_W    = 2 * DIM_W;
   localparam int CELLS     = MAX_DIM * MAX_DIM;
   localparam int CNT_W     = $clog2(CELLS + 1);
   localparam int VAL_W     = 48;
   localparam int ENT_W     = VAL_W + 1;
   localparam int DIM_CFG_W = 4;
   localparam int EXP_W     = 32;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 32;

   localparam logic [VAL_W-1:0] VMAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic [VAL_W-1:0] VMIN = {1'b1, {(VAL_W-1){1'b0}}};

   localparam logic [CSR_IDX_W-1:0] CSR_DIMENSION = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_EXPONENT  = CSR_IDX_W'(1);

   localparam logic [DIM_CFG_W-1:0] DIM_RESET = DIM_CFG_W'(MAX_DIM);
   localparam logic [EXP_W-1:0]     EXP_RESET = EXP_W'(1);

   // one product term travelling down the multiply-accumulate pipe
   typedef struct packed {
      logic              valid;
      logic              first;
      logic              lastk;
      logic [ADDR_W-1:0] addr;
   } tok_type;

   // accumulator write-back toward the product buffer
   typedef struct packed {
      logic              busy;
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [ENT_W-1:0]  data;
   } wr_type;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_COPY  = 7'b0000010,
      S_CHECK = 7'b0000100,
      S_MULT  = 7'b0001000,
      S_BACK  = 7'b0010000,
      S_SHIFT = 7'b0100000,
      S_EMIT  = 7'b1000000
   } state_type;

endpackage

// File: sv/mpp_ram.sv
`timescale 1ns / 1ps

module mpp_ram #(
   parameter int WIDTH = 49,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/mpp_mac.sv
`timescale 1ns / 1ps

module mpp_mac (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [mpp_pkg::ENT_W-1:0] a_ent,
   input  logic [mpp_pkg::ENT_W-1:0] b_ent,
   input  mpp_pkg::tok_type        tok,
   output mpp_pkg::wr_type         mac_wr
);

   import mpp_pkg::*;

   tok_type            tok2_ff;
   logic signed [VAL_W-1:0] sum_ff, sum_in;
   logic               sum_inf_ff, sum_inf_in;
   logic signed [VAL_W-1:0] best_ff, best_in;
   logic               best_inf_ff, best_inf_in;
   logic [VAL_W:0]     wide;
   logic               take;

   // stage one: saturating add, minus infinity absorbs
   always_comb begin
      wide       = {a_ent[VAL_W-1], a_ent[VAL_W-1:0]} + {b_ent[VAL_W-1], b_ent[VAL_W-1:0]};
      sum_inf_in = a_ent[VAL_W] | b_ent[VAL_W];
      if (wide[VAL_W] != wide[VAL_W-1]) begin
         sum_in = wide[VAL_W] ? VMIN : VMAX;
      end else begin
         sum_in = wide[VAL_W-1:0];
      end
   end

   // stage two: running max over k
   always_comb begin
      take = !sum_inf_ff && (tok2_ff.first || best_inf_ff || (sum_ff > best_ff));
      best_inf_in = tok2_ff.first ? sum_inf_ff : (best_inf_ff & sum_inf_ff);
      best_in     = take ? sum_ff : best_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok2_ff <= '0;
      end else begin
         tok2_ff <= tok;
      end
      sum_ff     <= sum_in;
      sum_inf_ff <= sum_inf_in;
      if (tok2_ff.valid) begin
         best_ff     <= best_in;
         best_inf_ff <= best_inf_in;
      end
   end

   always_comb begin
      mac_wr.busy = tok2_ff.valid;
      mac_wr.we   = tok2_ff.valid & tok2_ff.lastk;
      mac_wr.addr = tok2_ff.addr;
      mac_wr.data = {best_inf_in, best_inf_in ? '0 : best_in};
   end

endmodule

// File: sv/maxplus_matrix_power_unit.sv
`timescale 1ns / 1ps
// load: one element per cycle; the item flagged last starts the run and stalls the input
// run: copy of the loaded matrix, then per (max, +) product a pass through one
//   shared add/compare unit, a write-back and a check or shift step
// results: d*d elements leave one per cycle while the result side does not stall;
//   input reopens with the final element
// reset (synchronous, active high): idle, no result pending, dimension 8, exponent 1;
//   matrix stores hold no defined contents until loaded

module maxplus_matrix_power_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [mpp_pkg::DIM_W-1:0]         req_row,
   input  logic [mpp_pkg::DIM_W-1:0]         req_col,
   input  logic signed [mpp_pkg::VAL_W-1:0]  req_value,
   input  logic                              req_no_edge,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [mpp_pkg::DIM_W-1:0]         rsp_out_row,
   output logic [mpp_pkg::DIM_W-1:0]         rsp_out_col,
   output logic signed [mpp_pkg::VAL_W-1:0]  rsp_out_value,
   output logic                              rsp_out_no_edge,
   output logic                              rsp_out_last,
   input  logic                              csr_write_enable,
   input  logic [mpp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mpp_pkg::CSR_DAT_W-1:0]     csr_write_data
);

   import mpp_pkg::*;

   state_type            state_ff, state_in;
   logic [DIM_CFG_W-1:0] dim_cfg_ff;
   logic [EXP_W-1:0]     exp_cfg_ff;
   logic [DIM_W-1:0]     dm1_ff, dm1_in;
   logic [EXP_W-1:0]     rem_ff, rem_in;
   logic                 sqr_ff, sqr_in;
   logic [CNT_W-1:0]     cp_ff, cp_in;
   logic                 cp_v_ff, cp_v_in;
   logic [ADDR_W-1:0]    cp_addr_ff, cp_addr_in;
   logic [DIM_W-1:0]     ii_ff, ii_in, jj_ff, jj_in, kk_ff, kk_in;
   logic                 iss_done_ff, iss_done_in;
   tok_type              tok1_ff, tok1_in;
   logic [DIM_W-1:0]     oi_ff, oi_in, oj_ff, oj_in, oi_nx, oj_nx;
   logic                 data_ok_ff, data_ok_in;
   logic                 adv, out_last;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DIM_W-1:0]     rsp_row_ff, rsp_col_ff;
   logic [VAL_W-1:0]     rsp_value_ff;
   logic                 rsp_no_edge_ff, rsp_last_ff;

   logic                 base_we;
   logic [ADDR_W-1:0]    base_waddr;
   logic [ENT_W-1:0]     base_wdata, base_rd;
   logic                 res_we;
   logic [ENT_W-1:0]     res_wdata, res_rd;
   logic [ADDR_W-1:0]    res_raddr;
   logic                 scr_we;
   logic [ENT_W-1:0]     scr_wdata, scra_rd, scrb_rd;
   logic [ENT_W-1:0]     tmp_rd;
   wr_type               mac_wr;
   logic [ENT_W-1:0]     a_ent;
   logic                 sweep_end;

   assign req_stall = (state_ff != S_IDLE);

   assign base_we    = req_valid & ~req_stall;
   assign base_waddr = {req_row, req_col};
   assign base_wdata = {req_no_edge, req_no_edge ? '0 : req_value};

   assign sweep_end = (cp_ff == CNT_W'(CELLS)) && !cp_v_ff;
   assign a_ent     = sqr_ff ? scra_rd : res_rd;

   // output pointer walk, one element per cycle while the output register drains
   always_comb begin
      out_last = (oi_ff == dm1_ff) && (oj_ff == dm1_ff);
      oj_nx    = (oj_ff == dm1_ff) ? '0 : oj_ff + DIM_W'(1);
      oi_nx    = (oj_ff == dm1_ff) ? oi_ff + DIM_W'(1) : oi_ff;
      adv      = (state_ff == S_EMIT) && data_ok_ff && (!rsp_valid_ff || !rsp_stall);
   end

   always_comb begin
      state_in    = state_ff;
      dm1_in      = dm1_ff;
      rem_in      = rem_ff;
      sqr_in      = sqr_ff;
      cp_in       = cp_ff;
      cp_v_in     = 1'b0;
      cp_addr_in  = cp_ff[ADDR_W-1:0];
      ii_in       = ii_ff;
      jj_in       = jj_ff;
      kk_in       = kk_ff;
      iss_done_in = iss_done_ff;
      tok1_in     = '0;
      oi_in       = oi_ff;
      oj_in       = oj_ff;
      data_ok_in  = 1'b0;
      res_we      = 1'b0;
      res_wdata   = base_rd;
      scr_we      = 1'b0;
      scr_wdata   = base_rd;
      res_raddr   = adv ? {oi_nx, oj_nx} : {oi_ff, oj_ff};

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      case (state_ff)
         S_IDLE: begin
            if (base_we && req_last) begin
               if (dim_cfg_ff == '0) begin
                  dm1_in = '0;
               end else if (dim_cfg_ff > DIM_CFG_W'(MAX_DIM)) begin
                  dm1_in = DIM_W'(MAX_DIM - 1);
               end else begin
                  dm1_in = DIM_W'(dim_cfg_ff - DIM_CFG_W'(1));
               end
               rem_in   = (exp_cfg_ff == '0) ? '0 : exp_cfg_ff - EXP_W'(1);
               cp_in    = '0;
               state_in = S_COPY;
            end
         end
         S_COPY, S_BACK: begin
            cp_v_in = (cp_ff != CNT_W'(CELLS));
            if (cp_ff != CNT_W'(CELLS)) begin
               cp_in = cp_ff + CNT_W'(1);
            end
            if (state_ff == S_COPY) begin
               res_we = cp_v_ff;
               scr_we = cp_v_ff;
            end else begin
               res_we    = cp_v_ff & ~sqr_ff;
               scr_we    = cp_v_ff & sqr_ff;
               res_wdata = tmp_rd;
               scr_wdata = tmp_rd;
            end
            if (sweep_end) begin
               if (state_ff == S_COPY || sqr_ff) begin
                  state_in = S_CHECK;
               end else begin
                  state_in = S_SHIFT;
               end
            end
         end
         S_CHECK: begin
            ii_in       = '0;
            jj_in       = '0;
            kk_in       = '0;
            iss_done_in = 1'b0;
            oi_in       = '0;
            oj_in       = '0;
            if (rem_ff == '0) begin
               state_in = S_EMIT;
            end else if (rem_ff[0]) begin
               sqr_in   = 1'b0;
               state_in = S_MULT;
            end else begin
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            rem_in      = rem_ff >> 1;
            ii_in       = '0;
            jj_in       = '0;
            kk_in       = '0;
            iss_done_in = 1'b0;
            oi_in       = '0;
            oj_in       = '0;
            if ((rem_ff >> 1) != '0) begin
               sqr_in   = 1'b1;
               state_in = S_MULT;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_MULT: begin
            res_raddr = {ii_ff, kk_ff};
            if (!iss_done_ff) begin
               tok1_in.valid = 1'b1;
               tok1_in.first = (kk_ff == '0);
               tok1_in.lastk = (kk_ff == dm1_ff);
               tok1_in.addr  = {ii_ff, jj_ff};
               if (kk_ff != dm1_ff) begin
                  kk_in = kk_ff + DIM_W'(1);
               end else begin
                  kk_in = '0;
                  if (jj_ff != dm1_ff) begin
                     jj_in = jj_ff + DIM_W'(1);
                  end else begin
                     jj_in = '0;
                     if (ii_ff != dm1_ff) begin
                        ii_in = ii_ff + DIM_W'(1);
                     end else begin
                        iss_done_in = 1'b1;
                     end
                  end
               end
            end else if (!tok1_ff.valid && !mac_wr.busy) begin
               cp_in    = '0;
               state_in = S_BACK;
            end
         end
         S_EMIT: begin
            data_ok_in = 1'b1;
            if (adv) begin
               rsp_valid_in = 1'b1;
               if (out_last) begin
                  state_in = S_IDLE;
               end else begin
                  oi_in = oi_nx;
                  oj_in = oj_nx;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         dim_cfg_ff   <= DIM_RESET;
         exp_cfg_ff   <= EXP_RESET;
         rem_ff       <= '0;
         cp_v_ff      <= 1'b0;
         tok1_ff      <= '0;
         data_ok_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rem_ff       <= rem_in;
         cp_v_ff      <= cp_v_in;
         tok1_ff      <= tok1_in;
         data_ok_ff   <= data_ok_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_DIMENSION: dim_cfg_ff <= csr_write_data[DIM_CFG_W-1:0];
               CSR_EXPONENT:  exp_cfg_ff <= csr_write_data[EXP_W-1:0];
               default: begin
               end
            endcase
         end
      end
      dm1_ff      <= dm1_in;
      sqr_ff      <= sqr_in;
      cp_ff       <= cp_in;
      cp_addr_ff  <= cp_addr_in;
      ii_ff       <= ii_in;
      jj_ff       <= jj_in;
      kk_ff       <= kk_in;
      iss_done_ff <= iss_done_in;
      oi_ff       <= oi_in;
      oj_ff       <= oj_in;
      if (adv) begin
         rsp_row_ff     <= oi_ff;
         rsp_col_ff     <= oj_ff;
         rsp_value_ff   <= res_rd[ENT_W-1] ? '0 : res_rd[VAL_W-1:0];
         rsp_no_edge_ff <= res_rd[ENT_W-1];
         rsp_last_ff    <= out_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_row     = rsp_row_ff;
   assign rsp_out_col     = rsp_col_ff;
   assign rsp_out_value   = rsp_value_ff;
   assign rsp_out_no_edge = rsp_no_edge_ff;
   assign rsp_out_last    = rsp_last_ff;

   mpp_ram #(.WIDTH(ENT_W), .DEPTH(CELLS)) u_base (
      .clock (clock),
      .we    (base_we),
      .waddr (base_waddr),
      .wdata (base_wdata),
      .raddr (cp_ff[ADDR_W-1:0]),
      .rdata (base_rd)
   );

   mpp_ram #(.WIDTH(ENT_W), .DEPTH(CELLS)) u_result (
      .clock (clock),
      .we    (res_we),
      .waddr (cp_addr_ff),
      .wdata (res_wdata),
      .raddr (res_raddr),
      .rdata (res_rd)
   );

   // the running square is kept twice so a squaring reads row and column at once
   mpp_ram #(.WIDTH(ENT_W), .DEPTH(CELLS)) u_scratch_row (
      .clock (clock),
      .we    (scr_we),
      .waddr (cp_addr_ff),
      .wdata (scr_wdata),
      .raddr ({ii_ff, kk_ff}),
      .rdata (scra_rd)
   );

   mpp_ram #(.WIDTH(ENT_W), .DEPTH(CELLS)) u_scratch_col (
      .clock (clock),
      .we    (scr_we),
      .waddr (cp_addr_ff),
      .wdata (scr_wdata),
      .raddr ({kk_ff, jj_ff}),
      .rdata (scrb_rd)
   );

   mpp_ram #(.WIDTH(ENT_W), .DEPTH(CELLS)) u_product (
      .clock (clock),
      .we    (mac_wr.we),
      .waddr (mac_wr.addr),
      .wdata (mac_wr.data),
      .raddr (cp_ff[ADDR_W-1:0]),
      .rdata (tmp_rd)
   );

   mpp_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .a_ent  (a_ent),
      .b_ent  (scrb_rd),
      .tok    (tok1_ff),
      .mac_wr (mac_wr)
   );

endmodule

// File: sv/mpp_checker.sv
`timescale 1ns / 1ps

module mpp_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic                             req_last,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [mpp_pkg::DIM_W-1:0]        rsp_out_row,
   input logic [mpp_pkg::DIM_W-1:0]        rsp_out_col,
   input logic signed [mpp_pkg::VAL_W-1:0] rsp_out_value,
   input logic                             rsp_out_no_edge,
   input logic                             rsp_out_last
);

   // the flagged transaction starts a run, so the input closes
   a_last_closes_input: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last |=> req_stall)
      else $error("input still open after last transaction");

   // a plain load transaction leaves the input open
   a_load_keeps_open: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_last |=> !req_stall)
      else $error("input closed after a non-last transaction");

   // while the run still has results to give, no new transaction is taken
   a_no_accept_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_last |-> req_stall)
      else $error("input open while results of the run remain");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_row) && $stable(rsp_out_col)
         && $stable(rsp_out_value) && $stable(rsp_out_no_edge) && $stable(rsp_out_last))
      else $error("stalled result changed");

endmodule

bind maxplus_matrix_power_unit mpp_checker u_checker (.*);

// File: dv/tb_maxplus_matrix_power_unit.sv
`timescale 1ns / 1ps

typedef logic [mpp_pkg::ENT_W-1:0] mp_grid_type [mpp_pkg::CELLS];

typedef struct packed {
   logic [2:0]  row;
   logic [2:0]  col;
   logic [47:0] value;
   logic        no_edge;
   logic        last;
} power_elem_type;

class power_scoreboard;
   localparam longint WEIGHT_MAX = 64'sd140737488355327;
   localparam longint WEIGHT_MIN = -64'sd140737488355328;

   mp_grid_type    loaded;
   int unsigned    dim_reg;
   int unsigned    exp_reg;
   power_elem_type expected_q[$];
   int             errors;
   int             checked;

   function new();
      dim_reg = mpp_pkg::MAX_DIM;
      exp_reg = 1;
      errors  = 0;
      checked = 0;
      foreach (loaded[i]) loaded[i] = '0;
   endfunction

   function void write_register(logic [mpp_pkg::CSR_IDX_W-1:0] idx,
                                logic [mpp_pkg::CSR_DAT_W-1:0] data);
      if (idx == mpp_pkg::CSR_DIMENSION)
         dim_reg = 32'(data[3:0]);
      else if (idx == mpp_pkg::CSR_EXPONENT)
         exp_reg = data;
   endfunction

   // (max, +) product over the leading d x d block, saturating sums
   function void max_plus_mul(input mp_grid_type a, input mp_grid_type b, input int d,
                              output mp_grid_type prod);
      longint s;
      longint best;
      bit     have;
      prod = a;
      for (int i = 0; i < d; i++) begin
         for (int j = 0; j < d; j++) begin
            have = 0;
            best = 0;
            for (int k = 0; k < d; k++) begin
               if (a[i*8+k][48] || b[k*8+j][48])
                  continue;
               s = longint'($signed(a[i*8+k][47:0])) + longint'($signed(b[k*8+j][47:0]));
               if (s > WEIGHT_MAX) s = WEIGHT_MAX;
               if (s < WEIGHT_MIN) s = WEIGHT_MIN;
               if (!have || s > best) begin
                  best = s;
                  have = 1;
               end
            end
            prod[i*8+j] = have ? {1'b0, best[47:0]} : {1'b1, 48'b0};
         end
      end
   endfunction

   function void note_load(logic [2:0] row, logic [2:0] col, logic [47:0] value,
                           logic no_edge, logic last);
      mp_grid_type    acc;
      mp_grid_type    sq;
      int             d;
      int unsigned    rem;
      power_elem_type e;
      loaded[row*8+col] = no_edge ? {1'b1, 48'b0} : {1'b0, value};
      if (!last)
         return;
      d = dim_reg;
      if (d < 1) d = 1;
      if (d > mpp_pkg::MAX_DIM) d = mpp_pkg::MAX_DIM;
      rem = (exp_reg == 0) ? 0 : exp_reg - 1;
      acc = loaded;
      sq  = loaded;
      // square-and-multiply on the remaining exponent bits
      while (rem > 0) begin
         if (rem[0])
            max_plus_mul(acc, sq, d, acc);
         rem = rem >> 1;
         if (rem > 0)
            max_plus_mul(sq, sq, d, sq);
      end
      for (int i = 0; i < d; i++) begin
         for (int j = 0; j < d; j++) begin
            e.row     = i[2:0];
            e.col     = j[2:0];
            e.no_edge = acc[i*8+j][48];
            e.value   = acc[i*8+j][48] ? 48'b0 : acc[i*8+j][47:0];
            e.last    = (i == d - 1) && (j == d - 1);
            expected_q.push_back(e);
         end
      end
   endfunction

   function void report(string field, longint want, longint got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
   endfunction

   function void check_result(power_elem_type got);
      power_elem_type want;
      if (expected_q.size() == 0) begin
         errors++;
         $display("%0t: unexpected result transaction row %0d col %0d value %0d",
                  $time, got.row, got.col, $signed(got.value));
         return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.row != want.row) report("out_row", longint'(want.row), longint'(got.row));
      if (got.col != want.col) report("out_col", longint'(want.col), longint'(got.col));
      if (got.value != want.value)
         report("out_value", longint'($signed(want.value)), longint'($signed(got.value)));
      if (got.no_edge != want.no_edge)
         report("out_no_edge", longint'(want.no_edge), longint'(got.no_edge));
      if (got.last != want.last) report("out_last", longint'(want.last), longint'(got.last));
   endfunction

   function int pending();
      return expected_q.size();
   endfunction
endclass

module tb_maxplus_matrix_power_unit;
   import mpp_pkg::*;

   localparam int WATCHDOG_LIMIT = 200000;
   localparam int HOLD_CYCLES    = 300;
   localparam int PHASE_ITEMS    = 12;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [DIM_W-1:0]       req_row;
   logic [DIM_W-1:0]       req_col;
   logic signed [VAL_W-1:0] req_value;
   logic                   req_no_edge;
   logic                   req_last;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [DIM_W-1:0]       rsp_out_row;
   logic [DIM_W-1:0]       rsp_out_col;
   logic signed [VAL_W-1:0] rsp_out_value;
   logic                   rsp_out_no_edge;
   logic                   rsp_out_last;
   logic                   csr_write_enable;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DAT_W-1:0]   csr_write_data;

   power_scoreboard sb;
   int  send_idle_pct;
   int  recv_idle_pct;
   int  hold_requests;
   int  hold_served;
   int  items_sent;
   int  runs_sent;
   int  cur_dim;
   int  quiet_cycles;
   bit  written [CELLS];

   maxplus_matrix_power_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_row         (req_row),
      .req_col         (req_col),
      .req_value       (req_value),
      .req_no_edge     (req_no_edge),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_out_value   (rsp_out_value),
      .rsp_out_no_edge (rsp_out_no_edge),
      .rsp_out_last    (rsp_out_last),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // monitor and watchdog
   always @(posedge clock) begin
      power_elem_type got;
      bit             busy;
      if (!reset) begin
         busy = 0;
         if (csr_write_enable) begin
            sb.write_register(csr_index, csr_write_data);
            busy = 1;
         end
         if (req_valid && !req_stall) begin
            sb.note_load(req_row, req_col, req_value, req_no_edge, req_last);
            busy = 1;
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{row: rsp_out_row, col: rsp_out_col, value: rsp_out_value,
                    no_edge: rsp_out_no_edge, last: rsp_out_last};
            sb.check_result(got);
            busy = 1;
         end
         quiet_cycles = busy ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no transaction for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, sb.pending());
            $display("tb_maxplus_matrix_power_unit NOT OK");
            $finish;
         end
      end
   end

   // result side stall, with an occasional long hold-off
   initial begin
      rsp_stall   = 0;
      hold_served = 0;
      forever begin
         @(negedge clock);
         if (hold_requests != hold_served) begin
            hold_served++;
            rsp_stall = 1;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_stall = ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   function automatic logic [47:0] rand_weight();
      int k;
      k = $urandom_range(9);
      case (k)
         0: return VMAX;
         1: return VMIN;
         2: return 48'b0;
         3, 4: return 48'(int'($urandom_range(100)) - 50);
         5: return VMAX - 48'($urandom_range(1000));
         6: return VMIN + 48'($urandom_range(1000));
         default: return 48'({$urandom(), $urandom()});
      endcase
   endfunction

   function automatic logic rand_no_edge();
      return $urandom_range(99) < 15;
   endfunction

   function automatic bit block_ready(int d);
      for (int r = 0; r < d; r++)
         for (int c = 0; c < d; c++)
            if (!written[r*8+c]) return 0;
      return 1;
   endfunction

   task automatic send_item(int row, int col, logic [47:0] value, logic no_edge, logic last);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_row     = row[2:0];
      req_col     = col[2:0];
      req_value   = value;
      req_no_edge = no_edge;
      req_last    = last;
      req_valid   = 1;
      written[row*8+col] = 1;
      items_sent++;
      if (last) runs_sent++;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] data);
      @(negedge clock);
      req_valid        = 0;
      csr_index        = idx;
      csr_write_data   = data;
      csr_write_enable = 1;
      @(negedge clock);
      csr_write_enable = 0;
   endtask

   // let the block finish every pending result before touching registers
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_config(logic [3:0] dim, logic [31:0] power);
      logic [31:0] dim_data;
      wait_drained();
      dim_data      = $urandom();
      dim_data[3:0] = dim;
      if ($urandom_range(1)) begin
         csr_write(CSR_DIMENSION, dim_data);
         csr_write(CSR_EXPONENT, power);
      end else begin
         csr_write(CSR_EXPONENT, power);
         csr_write(CSR_DIMENSION, dim_data);
      end
      cur_dim = (dim == 0) ? 1 : (dim > MAX_DIM) ? MAX_DIM : dim;
   endtask

   task automatic random_config();
      int          k;
      int          d_eff;
      logic [3:0]  dim;
      logic [31:0] power;
      k = $urandom_range(99);
      if (k < 60)      dim = 4'($urandom_range(3, 1));
      else if (k < 80) dim = 4'($urandom_range(5, 4));
      else if (k < 88) dim = 4'($urandom_range(8, 6));
      else if (k < 96) dim = 0;
      else             dim = 4'($urandom_range(15, 9));
      d_eff = (dim == 0) ? 1 : (dim > MAX_DIM) ? MAX_DIM : dim;
      k = $urandom_range(99);
      if (k < 45)      power = $urandom_range(3, 1);
      else if (k < 70) power = $urandom_range(9, 4);
      else if (k < 80) power = 0;
      else if (k < 90) power = (d_eff <= 3) ? 32'hFFFF_FFFF : 32'd2;
      else             power = (d_eff <= 4) ? $urandom() : 32'd3;
      set_config(dim, power);
   endtask

   // full d x d load in shuffled order, with stray writes mixed in
   task automatic load_block(int d, int noise_pct);
      int cells[$];
      int j;
      int t;
      for (int r = 0; r < d; r++)
         for (int c = 0; c < d; c++)
            cells.push_back(r * 8 + c);
      for (int i = cells.size() - 1; i > 0; i--) begin
         j        = $urandom_range(i);
         t        = cells[i];
         cells[i] = cells[j];
         cells[j] = t;
      end
      foreach (cells[i]) begin
         if ($urandom_range(99) < noise_pct)
            send_item($urandom_range(7), $urandom_range(7), rand_weight(), rand_no_edge(), 0);
         send_item(cells[i] / 8, cells[i] % 8, rand_weight(), rand_no_edge(),
                   i == cells.size() - 1);
      end
   endtask

   task automatic random_run();
      int n;
      int pos;
      bit fin;
      if ($urandom_range(99) < 35)
         random_config();
      if ($urandom_range(99) < 80) begin
         load_block(cur_dim, 15);
      end else begin
         // scattered partial update, run only if the block in use is fully defined
         n = $urandom_range(cur_dim * cur_dim, 1);
         for (int i = 0; i < n; i++) begin
            pos = $urandom_range(CELLS - 1);
            fin = 0;
            if (i == n - 1) begin
               written[pos] = 1;
               fin = block_ready(cur_dim);
            end
            send_item(pos / 8, pos % 8, rand_weight(), rand_no_edge(), fin);
         end
      end
   endtask

   task automatic run_phase(int send_pct, int recv_pct);
      int start;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      start = items_sent;
      random_config();
      while (items_sent - start < PHASE_ITEMS)
         random_run();
   endtask

   initial begin
      sb               = new();
      reset            = 1;
      req_valid        = 0;
      req_row          = '0;
      req_col          = '0;
      req_value        = '0;
      req_no_edge      = 0;
      req_last         = 0;
      csr_write_enable = 0;
      csr_index        = CSR_DIMENSION;
      csr_write_data   = '0;
      send_idle_pct    = 6;
      recv_idle_pct    = 79;
      hold_requests    = 0;
      items_sent       = 0;
      runs_sent        = 0;
      cur_dim          = MAX_DIM;
      quiet_cycles     = 0;
      foreach (written[i]) written[i] = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // single element: extremes, saturation both ways, no edge
      set_config(1, 1);
      send_item(0, 0, VMAX, 0, 1);
      set_config(1, 2);
      send_item(0, 0, VMAX, 0, 1);
      send_item(0, 0, VMIN, 0, 1);
      send_item(0, 0, rand_weight(), 1, 1);
      // zero dimension and zero exponent behave as one
      set_config(0, 0);
      send_item(0, 0, -48'sd7, 0, 1);
      // 2x2 with all-ones exponent and a stored element outside the block
      set_config(2, 32'hFFFF_FFFF);
      send_item(7, 7, VMIN, 0, 0);
      send_item(0, 0, rand_weight(), 1, 0);
      send_item(0, 1, 48'sd1, 0, 0);
      send_item(1, 0, -48'sd1, 0, 0);
      send_item(1, 1, 48'sd0, 0, 1);
      set_config(2, 5);
      send_item(0, 0, 48'sd3, 0, 1);
      set_config(3, 3);
      send_item(0, 2, VMAX, 0, 0);
      send_item(1, 2, -48'sd2, 0, 0);
      send_item(2, 0, 48'sd5, 0, 0);
      send_item(2, 1, rand_weight(), 1, 0);
      send_item(2, 2, VMIN, 0, 1);

      // oversized dimension register clamps to the full 8x8 matrix
      set_config(15, 2);
      load_block(MAX_DIM, 0);
      run_phase(6, 79);

      send_idle_pct = 79;
      recv_idle_pct = 6;
      set_config(8, 32'hFFFF_FFFF);
      send_item($urandom_range(7), $urandom_range(7), rand_weight(), rand_no_edge(), 1);
      run_phase(79, 6);

      // long result hold-off while loads keep coming
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_config(2, 2);
      hold_requests++;
      load_block(2, 0);
      load_block(2, 0);
      run_phase(0, 0);

      wait_drained();
      repeat (200) @(negedge clock);
      $display("loaded %0d elements over %0d power runs, %0d result elements checked",
               items_sent, runs_sent, sb.checked);
      $display("dimensions 0..15, exponents 0 to all-ones, stalls on both sides and a long hold");
      if (sb.errors == 0 && sb.pending() == 0)
         $display("tb_maxplus_matrix_power_unit OK");
      else
         $display("tb_maxplus_matrix_power_unit NOT OK");
      $finish;
   end
endmodule

// File: maxplus_matrix_power_unit.f
sv/mpp_pkg.sv
sv/mpp_ram.sv
sv/mpp_mac.sv
sv/maxplus_matrix_power_unit.sv
sv/mpp_checker.sv
dv/tb_maxplus_matrix_power_unit.sv
